// ===== hw/rtl/frame_deframer_sum8_unit_defines.svh =====
// Assertion macros for the frame deframer.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef FRAME_DEFRAMER_SUM8_UNIT_DEFINES_SVH
`define FRAME_DEFRAMER_SUM8_UNIT_DEFINES_SVH

// cond must hold in the same cycle as trig
`define FDS8_ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// cond must hold in the cycle after trig
`define FDS8_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/fds8_pkg.sv =====
// Shared types and constants for the frame deframer.
// No dependencies.
package fds8_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LEN_W      = 12;

    localparam logic [CFG_IDX_W-1:0] REG_HEAD_BYTE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAME_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_DEVICE_ID = 3'd4;

    localparam logic [LEN_W-1:0] FLOOR_LEN    = 12'd8;
    localparam logic [LEN_W-1:0] DROP_SAT     = 12'd2048;
    localparam logic [15:0]      BROADCAST_ID = 16'hFFFF;

    typedef struct packed {
        logic [7:0]       head_byte;
        logic [7:0]       tail_byte;
        logic [LEN_W-1:0] min_frame_len;
        logic [LEN_W-1:0] max_frame_len;
        logic [15:0]      own_device_id;
    } cfg_t;

    typedef struct packed {
        logic [7:0]       command_code;
        logic [15:0]      target_id;
        logic [15:0]      source_id;
        logic [LEN_W-1:0] frame_length;
        logic             addressed;
        logic [LEN_W-1:0] dropped_count;
    } res_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD,
        S_HEAD_RD, S_HEAD_CK,
        S_LEN0_RD, S_LEN0_CK, S_LEN1_RD, S_LEN1_CK,
        S_SUM_RD, S_SUM_CK, S_CS_RD, S_CS_CK, S_TL_RD, S_TL_CK,
        S_FLD_RD, S_FLD_CK, S_EMIT
    } state_t;

endpackage

// ===== hw/rtl/fds8_ifs.sv =====
// Handshake channel interfaces: received bytes and decoded frames.
// Depends on nothing.
interface fds8_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface fds8_frame_if;
    logic        valid;
    logic        ready;
    logic [7:0]  command_code;
    logic [15:0] target_id;
    logic [15:0] source_id;
    logic [11:0] frame_length;
    logic        addressed;
    logic [11:0] dropped_count;

    modport source (output valid, output command_code, output target_id, output source_id,
                    output frame_length, output addressed, output dropped_count,
                    input ready);
    modport sink   (input valid, input command_code, input target_id, input source_id,
                    input frame_length, input addressed, input dropped_count,
                    output ready);
endinterface

// ===== hw/rtl/fds8_ram.sv =====
// Window byte store: one write port, one read port, registered read data.
// No dependencies.
module fds8_ram #(
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/fds8_scan.sv =====
// Window bookkeeping and frame scan sequencer over the byte store.
// Depends on fds8_pkg; drives an external fds8_ram.
module fds8_scan #(
    parameter int WINDOW_DEPTH = 2048,
    localparam int AW = $clog2(WINDOW_DEPTH)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  fds8_pkg::cfg_t  cfg,
    input  logic            in_valid,
    input  logic [7:0]      in_byte,
    output logic            in_ready,
    input  logic            slot_free,
    output logic            res_valid,
    output fds8_pkg::res_t  res,
    output logic            ram_we,
    output logic [AW-1:0]   ram_waddr,
    output logic [7:0]      ram_wdata,
    output logic [AW-1:0]   ram_raddr,
    input  logic [7:0]      ram_rdata
);

    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int OW = CW + 1;
    localparam int XW = 17;
    localparam int SW = 14;
    localparam int LW = fds8_pkg::LEN_W;
    localparam logic [XW-1:0] DEPTH_X = XW'(WINDOW_DEPTH);

    fds8_pkg::state_t state_reg, state_next;

    logic [AW-1:0] start_reg, start_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [LW-1:0] drop_reg, drop_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] k_reg, k_next;
    logic [LW-1:0] len_reg, len_next;
    logic [7:0]    len_lo_reg, len_lo_next;
    logic [7:0]    sum_reg, sum_next;
    logic          srch_reg, srch_next;
    logic [7:0]    cmd_reg, cmd_next;
    logic [15:0]   tgt_reg, tgt_next;
    logic [15:0]   src_reg, src_next;

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
        logic [OW-1:0] s;
        s = OW'(a) + OW'(b);
        if (s >= OW'(WINDOW_DEPTH))
        begin
            s = s - OW'(WINDOW_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [LW-1:0] sat_add(input logic [LW-1:0] d, input logic [CW-1:0] n);
        logic [SW-1:0] s;
        s = SW'(d) + SW'(n);
        return (s > SW'(fds8_pkg::DROP_SAT)) ? fds8_pkg::DROP_SAT : s[LW-1:0];
    endfunction

    // effective length limits, scan conditions and consumed length
    logic [XW-1:0] min_x, lo_x, lo_f, hi_x, max_x;
    logic [XW-1:0] fill_x, i_x, rem_x, len_x;
    logic [OW-1:0] off;
    logic [CW-1:0] consumed;
    logic          c_short, c_end, c_nohead, c_srch_short, c_hdr3;
    logic          c_badlen, c_incomp, c_sum_more, c_cs_bad, c_tl_bad, c_fld_last, full;

    always_comb
    begin
        min_x  = XW'(cfg.min_frame_len);
        max_x  = XW'(cfg.max_frame_len);
        lo_f   = (min_x < XW'(fds8_pkg::FLOOR_LEN)) ? XW'(fds8_pkg::FLOOR_LEN) : min_x;
        lo_x   = (lo_f > DEPTH_X) ? DEPTH_X : lo_f;
        hi_x   = (max_x > DEPTH_X) ? DEPTH_X : max_x;
        fill_x = XW'(fill_reg);
        i_x    = XW'(i_reg);
        rem_x  = fill_x - i_x;
        len_x  = XW'({ram_rdata, len_lo_reg});

        full         = (fill_x == DEPTH_X);
        c_short      = fill_x < lo_x;
        c_end        = i_x >= fill_x;
        c_nohead     = ram_rdata != cfg.head_byte;
        c_srch_short = srch_reg && (rem_x < lo_x);
        c_hdr3       = rem_x < XW'(3);
        c_badlen     = (len_x > hi_x) || (len_x < lo_x);
        c_incomp     = rem_x < len_x;
        c_sum_more   = (XW'(k_reg) + XW'(3)) < XW'(len_reg);
        c_cs_bad     = ram_rdata != sum_reg;
        c_tl_bad     = ram_rdata != cfg.tail_byte;
        c_fld_last   = k_reg == CW'(7);

        consumed = CW'(OW'(i_reg) + OW'(len_reg));
    end

    // read offset within the window for each issue state
    always_comb
    begin
        case (state_reg)
            fds8_pkg::S_LEN0_RD: off = OW'(i_reg) + OW'(1);
            fds8_pkg::S_LEN1_RD: off = OW'(i_reg) + OW'(2);
            fds8_pkg::S_SUM_RD,
            fds8_pkg::S_FLD_RD:  off = OW'(i_reg) + OW'(k_reg);
            fds8_pkg::S_CS_RD:   off = OW'(i_reg) + OW'(len_reg) - OW'(2);
            fds8_pkg::S_TL_RD:   off = OW'(i_reg) + OW'(len_reg) - OW'(1);
            default:             off = OW'(i_reg);
        endcase
    end

    assign ram_raddr = ring_add(start_reg, off[CW-1:0]);
    assign ram_waddr = ring_add(start_reg, fill_reg);
    assign ram_wdata = in_byte;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fds8_pkg::S_IDLE:    if (in_valid) state_next = fds8_pkg::S_LOAD;
            fds8_pkg::S_LOAD:
                state_next = c_short ? fds8_pkg::S_IDLE : fds8_pkg::S_HEAD_RD;
            fds8_pkg::S_HEAD_RD:
                state_next = c_end ? fds8_pkg::S_IDLE : fds8_pkg::S_HEAD_CK;
            fds8_pkg::S_HEAD_CK:
            begin
                if (c_nohead)
                    state_next = fds8_pkg::S_HEAD_RD;
                else if (c_srch_short || c_hdr3)
                    state_next = fds8_pkg::S_IDLE;
                else
                    state_next = fds8_pkg::S_LEN0_RD;
            end
            fds8_pkg::S_LEN0_RD: state_next = fds8_pkg::S_LEN0_CK;
            fds8_pkg::S_LEN0_CK: state_next = fds8_pkg::S_LEN1_RD;
            fds8_pkg::S_LEN1_RD: state_next = fds8_pkg::S_LEN1_CK;
            fds8_pkg::S_LEN1_CK:
            begin
                if (c_badlen)
                    state_next = fds8_pkg::S_HEAD_RD;
                else if (c_incomp)
                    state_next = fds8_pkg::S_IDLE;
                else
                    state_next = fds8_pkg::S_SUM_RD;
            end
            fds8_pkg::S_SUM_RD:  state_next = fds8_pkg::S_SUM_CK;
            fds8_pkg::S_SUM_CK:
                state_next = c_sum_more ? fds8_pkg::S_SUM_RD : fds8_pkg::S_CS_RD;
            fds8_pkg::S_CS_RD:   state_next = fds8_pkg::S_CS_CK;
            fds8_pkg::S_CS_CK:
                state_next = c_cs_bad ? fds8_pkg::S_HEAD_RD : fds8_pkg::S_TL_RD;
            fds8_pkg::S_TL_RD:   state_next = fds8_pkg::S_TL_CK;
            fds8_pkg::S_TL_CK:
                state_next = c_tl_bad ? fds8_pkg::S_HEAD_RD : fds8_pkg::S_FLD_RD;
            fds8_pkg::S_FLD_RD:  state_next = fds8_pkg::S_FLD_CK;
            fds8_pkg::S_FLD_CK:
                state_next = c_fld_last ? fds8_pkg::S_EMIT : fds8_pkg::S_FLD_RD;
            fds8_pkg::S_EMIT:    if (slot_free) state_next = fds8_pkg::S_IDLE;
            default:             state_next = fds8_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        start_next  = start_reg;
        fill_next   = fill_reg;
        drop_next   = drop_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        len_next    = len_reg;
        len_lo_next = len_lo_reg;
        sum_next    = sum_reg;
        srch_next   = srch_reg;
        cmd_next    = cmd_reg;
        tgt_next    = tgt_reg;
        src_next    = src_reg;
        ram_we      = 1'b0;
        in_ready    = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            fds8_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ram_we = 1'b1;
                    if (full)
                    begin
                        // oldest byte is pushed out
                        start_next = ring_add(start_reg, CW'(1));
                        drop_next  = sat_add(drop_reg, CW'(1));
                    end
                    else
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                end
            end
            fds8_pkg::S_LOAD:
            begin
                i_next    = '0;
                srch_next = 1'b0;
            end
            fds8_pkg::S_HEAD_RD:
            begin
                if (c_end)
                begin
                    start_next = ring_add(start_reg, fill_reg);
                    fill_next  = '0;
                    drop_next  = sat_add(drop_reg, fill_reg);
                end
            end
            fds8_pkg::S_HEAD_CK:
            begin
                if (c_nohead)
                begin
                    i_next    = i_reg + CW'(1);
                    srch_next = 1'b1;
                end
                else if (c_srch_short || c_hdr3)
                begin
                    start_next = ring_add(start_reg, i_reg);
                    fill_next  = fill_reg - i_reg;
                    drop_next  = sat_add(drop_reg, i_reg);
                end
                else
                begin
                    srch_next = 1'b0;
                end
            end
            fds8_pkg::S_LEN0_CK:
            begin
                len_lo_next = ram_rdata;
            end
            fds8_pkg::S_LEN1_CK:
            begin
                if (c_badlen)
                begin
                    i_next = i_reg + CW'(1);
                end
                else if (c_incomp)
                begin
                    // a head at window byte 0 waits; dropping zero bytes is a no-op
                    start_next = ring_add(start_reg, i_reg);
                    fill_next  = fill_reg - i_reg;
                    drop_next  = sat_add(drop_reg, i_reg);
                end
                else
                begin
                    len_next = len_x[LW-1:0];
                    k_next   = CW'(1);
                    sum_next = '0;
                end
            end
            fds8_pkg::S_SUM_CK:
            begin
                sum_next = sum_reg + ram_rdata;
                k_next   = k_reg + CW'(1);
            end
            fds8_pkg::S_CS_CK:
            begin
                if (c_cs_bad)
                    i_next = i_reg + CW'(1);
            end
            fds8_pkg::S_TL_CK:
            begin
                if (c_tl_bad)
                    i_next = i_reg + CW'(1);
                else
                    k_next = CW'(3);
            end
            fds8_pkg::S_FLD_CK:
            begin
                case (k_reg[2:0])
                    3'd3:    cmd_next = ram_rdata;
                    3'd4:    tgt_next[7:0] = ram_rdata;
                    3'd5:    tgt_next[15:8] = ram_rdata;
                    3'd6:    src_next[7:0] = ram_rdata;
                    3'd7:    src_next[15:8] = ram_rdata;
                    default: cmd_next = cmd_reg;
                endcase
                k_next = k_reg + CW'(1);
            end
            fds8_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    res_valid  = 1'b1;
                    start_next = ring_add(start_reg, consumed);
                    fill_next  = fill_reg - consumed;
                    drop_next  = '0;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res.command_code  = cmd_reg;
        res.target_id     = tgt_reg;
        res.source_id     = src_reg;
        res.frame_length  = len_reg;
        res.addressed     = (tgt_reg == cfg.own_device_id) ||
                            (cfg.own_device_id == fds8_pkg::BROADCAST_ID);
        res.dropped_count = sat_add(drop_reg, i_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fds8_pkg::S_IDLE;
            start_reg <= '0;
            fill_reg  <= '0;
            drop_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            fill_reg  <= fill_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        k_reg      <= k_next;
        len_reg    <= len_next;
        len_lo_reg <= len_lo_next;
        sum_reg    <= sum_next;
        srch_reg   <= srch_next;
        cmd_reg    <= cmd_next;
        tgt_reg    <= tgt_next;
        src_reg    <= src_next;
    end

endmodule

// ===== hw/rtl/frame_deframer_sum8_unit.sv =====
// Top level of the byte frame deframer: config registers, result register.
// Depends on fds8_pkg, fds8_ifs, fds8_ram, fds8_scan and the defines header.
//
//  channel  dir   handshake     payload
//  rx       in    valid/ready   data_byte
//  frame    out   valid/ready   command_code, target_id, source_id,
//                               frame_length, addressed, dropped_count
//  cfg      in    cfg_we        cfg_index, cfg_data
//
// One item at a time: a byte that starts no scan passes S_IDLE and S_LOAD only;
// a scan reads the byte store with a read state and a check state per byte, and
// each rescan after a head whose frame check fails reads those bytes again.
// Reset clears window fill and drop count; the store itself is not cleared.
// A result waits in the output register; the next item is taken meanwhile,
// and the scan only stalls if a second frame is ready before the first leaves.
`include "frame_deframer_sum8_unit_defines.svh"

module frame_deframer_sum8_unit #(
    parameter int WINDOW_DEPTH = 2048
) (
    input  logic                               clk,
    input  logic                               rst_n,
    fds8_rx_if.sink                            rx,
    fds8_frame_if.source                       frame,
    input  logic                               cfg_we,
    input  logic [fds8_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fds8_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    fds8_pkg::cfg_t cfg_reg, cfg_next;
    fds8_pkg::res_t res, out_reg;
    logic           out_valid_reg, out_valid_next;
    logic           res_valid, slot_free;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [7:0]     ram_wdata, ram_rdata;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                fds8_pkg::REG_HEAD_BYTE:     cfg_next.head_byte     = cfg_data[7:0];
                fds8_pkg::REG_TAIL_BYTE:     cfg_next.tail_byte     = cfg_data[7:0];
                fds8_pkg::REG_MIN_FRAME_LEN: cfg_next.min_frame_len = cfg_data[11:0];
                fds8_pkg::REG_MAX_FRAME_LEN: cfg_next.max_frame_len = cfg_data[11:0];
                fds8_pkg::REG_OWN_DEVICE_ID: cfg_next.own_device_id = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.head_byte     <= 8'd0;
            cfg_reg.tail_byte     <= 8'd0;
            cfg_reg.min_frame_len <= 12'd8;
            cfg_reg.max_frame_len <= 12'd1200;
            cfg_reg.own_device_id <= 16'hFFFF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fds8_ram #(
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fds8_scan #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (rx.valid),
        .in_byte   (rx.data_byte),
        .in_ready  (rx.ready),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    assign slot_free = !out_valid_reg || frame.ready;

    always_comb
    begin
        if (res_valid)
            out_valid_next = 1'b1;
        else if (frame.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign frame.valid         = out_valid_reg;
    assign frame.command_code  = out_reg.command_code;
    assign frame.target_id     = out_reg.target_id;
    assign frame.source_id     = out_reg.source_id;
    assign frame.frame_length  = out_reg.frame_length;
    assign frame.addressed     = out_reg.addressed;
    assign frame.dropped_count = out_reg.dropped_count;

    `FDS8_ASSERT_NEXT(a_busy_after_item, rx.valid && rx.ready, !rx.ready, "scan idle after item")
    `FDS8_ASSERT_SAME(a_result_slot_free, res_valid, slot_free, "result overwrote pending frame")
    `FDS8_ASSERT_SAME(a_no_result_in_idle, res_valid, !rx.ready, "result while taking an item")

endmodule
